// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL. Bodies compile away when SYNTH is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Property that must hold at every clock edge out of reset.
`define AFC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// When cond holds, prop must hold in the next cycle.
`define AFC_ASSERT_NEXT(lbl, clk, rst_n, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`else

`define AFC_ASSERT(lbl, clk, rst_n, prop, msg)
`define AFC_ASSERT_NEXT(lbl, clk, rst_n, cond, prop, msg)

`endif

`endif

// File: hw/rtl/afc_pkg.sv
package afc_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int MAT_REGS        = 8;
    localparam int MAT_IDX_W       = 3;
    localparam int PLANES          = 6;
    localparam int NCOMP           = 4;
    localparam int HALF_W          = 32;
    localparam int COMP_W          = HALF_W + 1;
    localparam int Q_FRAC          = 16;
    localparam int APB_DW          = 64;
    localparam int ADDR_LSB        = 3;
    localparam int APB_AW          = MAT_IDX_W + ADDR_LSB;

    // Component slots of a plane: normal x, y, z and offset.
    localparam int COMP_X = 0;
    localparam int COMP_Y = 1;
    localparam int COMP_Z = 2;
    localparam int COMP_D = 3;

    typedef enum logic [MAT_IDX_W-1:0] {
        REG_R0_C01 = 3'd0,
        REG_R0_C23 = 3'd1,
        REG_R1_C01 = 3'd2,
        REG_R1_C23 = 3'd3,
        REG_R2_C01 = 3'd4,
        REG_R2_C23 = 3'd5,
        REG_R3_C01 = 3'd6,
        REG_R3_C23 = 3'd7
    } reg_idx_t;

    typedef logic signed [COMP_W-1:0] comp_t;

    // Per-stage advance strobes of the datapath pipeline.
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } afc_adv_t;

    // One Q16.16 half of a matrix register, widened to a plane component.
    function automatic comp_t elem_q(input logic [APB_DW-1:0] word, input logic odd);
        logic signed [HALF_W-1:0] h;
        h = odd ? word[APB_DW-1:HALF_W] : word[HALF_W-1:0];
        return COMP_W'(h);
    endfunction

endpackage

// File: hw/rtl/aabb_frustum_cull.sv
// Channel   Signals                                          Direction   Moves
// box       box_valid, box_stall, box_min_*, box_max_*       in          one box request
// res       res_valid, res_stall, visible                    out         one cull result
// cfg       psel/penable/pwrite/paddr/pwdata/prdata/pready   in/out      one 64-bit matrix reg
//
// Throughput is one box per cycle unless a stall on res backs up the pipeline; a box
// passes through the four register stages: partial products, product merge, pair
// sums, final sum with the six-plane vote.
// Reset clears the matrix, the derived planes and every valid bit; no clearing pass.
// A stall on res holds only the stages that are full: bubbles squeeze out, and
// box_stall rises only when all four stages hold a request.

`include "assert_macros.svh"

module aabb_frustum_cull
    import afc_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          box_valid,
    output logic                          box_stall,
    input  logic signed [COORD_WIDTH-1:0] box_min_x,
    input  logic signed [COORD_WIDTH-1:0] box_min_y,
    input  logic signed [COORD_WIDTH-1:0] box_min_z,
    input  logic signed [COORD_WIDTH-1:0] box_max_x,
    input  logic signed [COORD_WIDTH-1:0] box_max_y,
    input  logic signed [COORD_WIDTH-1:0] box_max_z,

    output logic                          res_valid,
    input  logic                          res_stall,
    output logic                          visible,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [APB_AW-1:0]             paddr,
    input  logic [APB_DW-1:0]             pwdata,
    output logic [APB_DW-1:0]             prdata,
    output logic                          pready
);

    comp_t                         plane [PLANES][NCOMP];
    logic signed [COORD_WIDTH-1:0] corner_lo [3];
    logic signed [COORD_WIDTH-1:0] corner_hi [3];
    logic [PLANES-1:0]             neg;
    afc_adv_t                      adv;

    logic v1_reg;
    logic v2_reg;
    logic v3_reg;
    logic res_valid_reg;
    logic visible_reg;
    logic v1_next;
    logic v2_next;
    logic v3_next;
    logic res_valid_next;

    // Matrix registers and the six planes derived from them.
    afc_plane u_plane (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .plane   (plane)
    );

    assign corner_lo[0] = box_min_x;
    assign corner_lo[1] = box_min_y;
    assign corner_lo[2] = box_min_z;
    assign corner_hi[0] = box_max_x;
    assign corner_hi[1] = box_max_y;
    assign corner_hi[2] = box_max_z;

    // Advance a stage when it is empty or the stage after it advances.
    assign adv.s4    = !res_valid_reg || !res_stall;
    assign adv.s3    = !v3_reg || adv.s4;
    assign adv.s2    = !v2_reg || adv.s3;
    assign adv.s1    = !v1_reg || adv.s2;
    assign box_stall = !adv.s1;

    assign v1_next        = adv.s1 ? box_valid : v1_reg;
    assign v2_next        = adv.s2 ? v1_reg    : v2_reg;
    assign v3_next        = adv.s3 ? v2_reg    : v3_reg;
    assign res_valid_next = adv.s4 ? v3_reg    : res_valid_reg;

    // One dot-product pipeline per frustum plane.
    for (genvar k = 0; k < PLANES; k++)
    begin : g_dot
        afc_dot #(
            .COORD_WIDTH (COORD_WIDTH)
        ) u_dot (
            .clk       (clk),
            .adv       (adv),
            .norm      (plane[k]),
            .corner_lo (corner_lo),
            .corner_hi (corner_hi),
            .neg       (neg[k])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            v1_reg        <= v1_next;
            v2_reg        <= v2_next;
            v3_reg        <= v3_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Drop the box if any plane puts its far corner behind.
    always_ff @(posedge clk)
    begin
        if (adv.s4)
        begin
            visible_reg <= ~|neg;
        end
    end

    assign res_valid = res_valid_reg;
    assign visible   = visible_reg;

    `AFC_ASSERT(a_stall_full, clk, rst_n, box_stall |-> (v1_reg && v2_reg && v3_reg && res_valid_reg), "box stalled with a free stage")
    `AFC_ASSERT(a_empty_open, clk, rst_n, (!v1_reg && !v2_reg && !v3_reg && !res_valid_reg) |-> !box_stall, "empty pipeline stalls boxes")
    `AFC_ASSERT_NEXT(a_drain, clk, rst_n, v3_reg && !res_stall, res_valid, "last stage request lost on the way out")

endmodule

// File: hw/rtl/afc_plane.sv
`include "assert_macros.svh"

module afc_plane
    import afc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output comp_t             plane [PLANES][NCOMP]
);

    logic [APB_DW-1:0]    mat_reg  [MAT_REGS];
    logic [APB_DW-1:0]    mat_next [MAT_REGS];
    comp_t                plane_reg  [PLANES][NCOMP];
    comp_t                plane_next [PLANES][NCOMP];
    logic                 wr_en;
    logic [MAT_IDX_W-1:0] wr_idx;
    comp_t                left_x_exp;
    comp_t                far_d_exp;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign wr_idx = paddr[APB_AW-1:ADDR_LSB];
    assign prdata = mat_reg[wr_idx];

    always_comb
    begin
        for (int j = 0; j < MAT_REGS; j++)
        begin
            mat_next[j] = (wr_en && (wr_idx == MAT_IDX_W'(j))) ? pwdata : mat_reg[j];
        end
    end

    // Plane k: row 3 plus (even k) or minus (odd k) row k/2.
    for (genvar k = 0; k < PLANES; k++)
    begin : g_plane
        for (genvar i = 0; i < NCOMP; i++)
        begin : g_comp
            localparam int ROW_IDX  = (k / 2) * 2 + i / 2;
            localparam int BASE_IDX = int'(REG_R3_C01) + i / 2;
            localparam int ODD_COL  = i % 2;
            comp_t base_v;
            comp_t other_v;

            assign base_v  = elem_q(mat_next[BASE_IDX], 1'(ODD_COL));
            assign other_v = elem_q(mat_next[ROW_IDX], 1'(ODD_COL));
            assign plane_next[k][i] = ((k % 2) == 1) ? base_v - other_v : base_v + other_v;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < MAT_REGS; j++)
            begin
                mat_reg[j] <= '0;
            end
            for (int k = 0; k < PLANES; k++)
            begin
                for (int i = 0; i < NCOMP; i++)
                begin
                    plane_reg[k][i] <= '0;
                end
            end
        end
        else
        begin
            mat_reg   <= mat_next;
            plane_reg <= plane_next;
        end
    end

    assign plane = plane_reg;

    assign left_x_exp = elem_q(mat_reg[REG_R3_C01], 1'b0) + elem_q(mat_reg[REG_R0_C01], 1'b0);
    assign far_d_exp  = elem_q(mat_reg[REG_R3_C23], 1'b1) - elem_q(mat_reg[REG_R2_C23], 1'b1);

    `AFC_ASSERT(a_left_x, clk, rst_n, plane_reg[0][COMP_X] == left_x_exp, "left plane x stale")
    `AFC_ASSERT(a_far_d, clk, rst_n, plane_reg[5][COMP_D] == far_d_exp, "far plane offset stale")
    `AFC_ASSERT(a_pready, clk, rst_n, pready, "pready dropped")

endmodule

// File: hw/rtl/afc_dot.sv
module afc_dot
    import afc_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic                          clk,
    input  afc_adv_t                      adv,
    input  comp_t                         norm      [NCOMP],
    input  logic signed [COORD_WIDTH-1:0] corner_lo [3],
    input  logic signed [COORD_WIDTH-1:0] corner_hi [3],
    output logic                          neg
);

    localparam int LO_W   = COORD_WIDTH / 2;
    localparam int HI_W   = COORD_WIDTH - LO_W;
    localparam int PL_W   = COMP_W + LO_W + 1;
    localparam int PH_W   = COMP_W + HI_W;
    localparam int PROD_W = COMP_W + COORD_WIDTH;
    localparam int SUM_W  = PROD_W + 2;

    logic signed [COORD_WIDTH-1:0] sel [3];
    logic signed [PL_W-1:0]        pl_next   [3];
    logic signed [PL_W-1:0]        pl_reg    [3];
    logic signed [PH_W-1:0]        ph_next   [3];
    logic signed [PH_W-1:0]        ph_reg    [3];
    logic signed [PROD_W-1:0]      prod_next [3];
    logic signed [PROD_W-1:0]      prod_reg  [3];
    logic signed [SUM_W-1:0]       sum_a_next;
    logic signed [SUM_W-1:0]       sum_b_next;
    logic signed [SUM_W-1:0]       sum_a_reg;
    logic signed [SUM_W-1:0]       sum_b_reg;
    logic signed [SUM_W-1:0]       total;

    // Pick the far corner, then multiply by the low (unsigned) and high (signed) halves.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sel[i]     = norm[i][COMP_W-1] ? corner_lo[i] : corner_hi[i];
            pl_next[i] = norm[i] * $signed({1'b0, sel[i][LO_W-1:0]});
            ph_next[i] = norm[i] * $signed(sel[i][COORD_WIDTH-1:LO_W]);
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            prod_next[i] = (PROD_W'(ph_reg[i]) <<< LO_W) + PROD_W'(pl_reg[i]);
        end
    end

    assign sum_a_next = SUM_W'(prod_reg[0]) + SUM_W'(prod_reg[1]);
    assign sum_b_next = SUM_W'(prod_reg[2]) + (SUM_W'(norm[COMP_D]) <<< Q_FRAC);
    assign total      = sum_a_reg + sum_b_reg;
    assign neg        = total[SUM_W-1];

    always_ff @(posedge clk)
    begin
        if (adv.s1)
        begin
            pl_reg <= pl_next;
            ph_reg <= ph_next;
        end
        if (adv.s2)
        begin
            prod_reg <= prod_next;
        end
        if (adv.s3)
        begin
            sum_a_reg <= sum_a_next;
            sum_b_reg <= sum_b_next;
        end
    end

endmodule
